>>> sv/gfpm_pkg.sv
// gfpm_pkg: sizes, payload structs, op codes and sequencer states for the
// polynomial multiply-and-reduce unit; no dependencies
package gfpm_pkg;

   localparam int DEG_T    = 64;
   localparam int FIELD_M  = 13;
   localparam int POLY_LEN = DEG_T + 1;
   localparam int PROD_LEN = 2 * DEG_T + 1;
   localparam int PAIRS    = DEG_T / 2 + 1;
   localparam int PIDX_W   = $clog2(POLY_LEN);
   localparam int PADDR_W  = $clog2(PROD_LEN);
   localparam int PAIR_W   = 6;
   localparam int BIT_W    = $clog2(FIELD_M);
   localparam int CSR_W    = 13;
   localparam logic [CSR_W-1:0] FIELD_POLY_RST = CSR_W'(27);

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_LOAD_G  = 2'd2,
      OP_COMPUTE = 2'd3
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [6:0]  coef_index;
      logic [12:0] coef_value;
   } req_type;

   typedef struct packed {
      logic [12:0]       coef_even;
      logic [12:0]       coef_odd;
      logic [PAIR_W-1:0] pair_index;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DG_RD,
      ST_DG_CHK,
      ST_PM_RD,
      ST_LD,
      ST_MUL,
      ST_WB,
      ST_RL_RD,
      ST_RL_LEAD,
      ST_RJ_RD,
      ST_O_EV,
      ST_O_OD,
      ST_O_PUT
   } state_type;

endpackage

>>> sv/gfpm_ram.sv
// gfpm_ram: generic single-write, single-read ram with registered read data
// no dependencies
module gfpm_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 65
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

>>> sv/gf2m_poly_mul_mod_unit.sv
// gf2m_poly_mul_mod_unit: a*b mod g over GF(2^m), one bit-serial multiplier
// depends on gfpm_pkg and gfpm_ram (a, b, g and product stores)
//
//   channel | ports                          | direction | handshake
//   req     | req_valid req_stall req_payload | in        | valid / stall
//   rsp     | rsp_valid rsp_stall rsp_payload | out       | valid / stall
//   csr     | csr_valid csr_ready csr_data    | in        | valid / ready
//
// a load item is taken while idle; a compute item stalls the input until its
// last result pair is in the output register, with every product formed by
// the one bit-serial multiplier and the product store read and written at
// one address. reset is synchronous and clears the a, b and g stores through
// valid bits, so no clearing pass is needed. a stalled result is held in the
// output register; the last one may wait while loads go on.
module gf2m_poly_mul_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  gfpm_pkg::req_type     req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output gfpm_pkg::rsp_type     rsp_payload,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [gfpm_pkg::CSR_W-1:0] csr_data
);

   localparam int M  = gfpm_pkg::FIELD_M;
   localparam int PW = gfpm_pkg::PIDX_W;
   localparam int AW = gfpm_pkg::PADDR_W;
   localparam int KW = gfpm_pkg::PAIR_W;

   gfpm_pkg::state_type state_ff, state_in;
   logic [gfpm_pkg::CSR_W-1:0] field_poly_ff;
   logic [gfpm_pkg::POLY_LEN-1:0] a_vld_ff, b_vld_ff, g_vld_ff;
   logic [gfpm_pkg::POLY_LEN-1:0] a_vld_in, b_vld_in, g_vld_in;
   logic a_ok_ff, b_ok_ff, g_ok_ff;
   logic [AW-1:0] i_ff, i_in;
   logic [PW-1:0] j_ff, j_in, d_ff, d_in;
   logic d_ok_ff, d_ok_in, red_ff, red_in;
   logic [M-1:0] x_ff, x_in, y_ff, y_in, acc_ff, acc_in, lead_ff, lead_in;
   logic [M-1:0] even_ff, even_in;
   logic [gfpm_pkg::BIT_W-1:0] bit_ff, bit_in;
   logic [KW-1:0] k_ff, k_in;
   gfpm_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [PW-1:0] a_raddr, b_raddr, g_raddr, wr_idx;
   logic [AW-1:0] p_raddr, even_addr, odd_addr;
   logic [M-1:0] a_q, b_q, g_q, p_q, a_data, b_data, g_data, mul_next, p_wdata;
   logic a_we, b_we, g_we, p_we, idx_ok;

   assign a_data  = a_ok_ff ? a_q : '0;
   assign b_data  = b_ok_ff ? b_q : '0;
   assign g_data  = g_ok_ff ? g_q : '0;
   assign wr_idx  = req_payload.coef_index[PW-1:0];
   assign idx_ok  = req_payload.coef_index <= 7'(gfpm_pkg::DEG_T);
   assign a_raddr = i_ff[PW-1:0];
   assign b_raddr = j_ff;
   assign g_raddr = (state_ff == gfpm_pkg::ST_DG_RD) ? i_ff[PW-1:0] : j_ff;
   assign even_addr = {1'b0, k_ff, 1'b0};
   assign odd_addr  = {1'b0, k_ff, 1'b1};

   always_comb begin
      unique case (state_ff)
         gfpm_pkg::ST_RL_RD:                   p_raddr = i_ff;
         gfpm_pkg::ST_O_EV:                    p_raddr = even_addr;
         gfpm_pkg::ST_O_OD, gfpm_pkg::ST_O_PUT: p_raddr = odd_addr;
         default: p_raddr = red_ff ? (i_ff - AW'(d_ff) + AW'(j_ff))
                                   : (i_ff + AW'(j_ff));
      endcase
   end

   // one step of the msb-first shift-and-add multiplier
   assign mul_next = {acc_ff[M-2:0], 1'b0}
                   ^ (acc_ff[M-1] ? field_poly_ff[M-1:0] : '0)
                   ^ (y_ff[M-1] ? x_ff : '0);

   // first touch of a product entry overwrites, so no clearing is needed
   assign p_wdata = (!red_ff && (i_ff == '0 || j_ff == PW'(gfpm_pkg::DEG_T)))
                  ? acc_ff : (acc_ff ^ p_q);

   gfpm_ram #(.WIDTH(M), .DEPTH(gfpm_pkg::POLY_LEN)) u_a_ram (
      .clock(clock), .wr_en(a_we), .wr_addr(wr_idx),
      .wr_data(req_payload.coef_value[M-1:0]), .rd_addr(a_raddr), .rd_data(a_q));
   gfpm_ram #(.WIDTH(M), .DEPTH(gfpm_pkg::POLY_LEN)) u_b_ram (
      .clock(clock), .wr_en(b_we), .wr_addr(wr_idx),
      .wr_data(req_payload.coef_value[M-1:0]), .rd_addr(b_raddr), .rd_data(b_q));
   gfpm_ram #(.WIDTH(M), .DEPTH(gfpm_pkg::POLY_LEN)) u_g_ram (
      .clock(clock), .wr_en(g_we), .wr_addr(wr_idx),
      .wr_data(req_payload.coef_value[M-1:0]), .rd_addr(g_raddr), .rd_data(g_q));
   gfpm_ram #(.WIDTH(M), .DEPTH(gfpm_pkg::PROD_LEN)) u_p_ram (
      .clock(clock), .wr_en(p_we), .wr_addr(p_raddr),
      .wr_data(p_wdata), .rd_addr(p_raddr), .rd_data(p_q));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= gfpm_pkg::ST_IDLE;
         field_poly_ff <= gfpm_pkg::FIELD_POLY_RST;
         a_vld_ff      <= '0;
         b_vld_ff      <= '0;
         g_vld_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         red_ff        <= 1'b0;
         d_ok_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_vld_ff     <= a_vld_in;
         b_vld_ff     <= b_vld_in;
         g_vld_ff     <= g_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         red_ff       <= red_in;
         d_ok_ff      <= d_ok_in;
         if (csr_valid) begin
            field_poly_ff <= csr_data;
         end
      end
      a_ok_ff <= a_vld_ff[a_raddr];
      b_ok_ff <= b_vld_ff[b_raddr];
      g_ok_ff <= g_vld_ff[g_raddr];
      i_ff    <= i_in;
      j_ff    <= j_in;
      d_ff    <= d_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      acc_ff  <= acc_in;
      lead_ff <= lead_in;
      even_ff <= even_in;
      bit_ff  <= bit_in;
      k_ff    <= k_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      a_vld_in     = a_vld_ff;
      b_vld_in     = b_vld_ff;
      g_vld_in     = g_vld_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      d_in         = d_ff;
      d_ok_in      = d_ok_ff;
      red_in       = red_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      lead_in      = lead_ff;
      even_in      = even_ff;
      bit_in       = bit_ff;
      k_in         = k_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      a_we         = 1'b0;
      b_we         = 1'b0;
      g_we         = 1'b0;
      p_we         = 1'b0;
      unique case (state_ff)
         gfpm_pkg::ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.op)
                  gfpm_pkg::OP_LOAD_A: begin
                     a_we = idx_ok;
                     if (idx_ok) a_vld_in[wr_idx] = 1'b1;
                  end
                  gfpm_pkg::OP_LOAD_B: begin
                     b_we = idx_ok;
                     if (idx_ok) b_vld_in[wr_idx] = 1'b1;
                  end
                  gfpm_pkg::OP_LOAD_G: begin
                     g_we = idx_ok;
                     if (idx_ok) g_vld_in[wr_idx] = 1'b1;
                  end
                  gfpm_pkg::OP_COMPUTE: begin
                     i_in     = '0;
                     d_ok_in  = 1'b0;
                     state_in = gfpm_pkg::ST_DG_RD;
                  end
                  default: ;
               endcase
            end
         end
         gfpm_pkg::ST_DG_RD: state_in = gfpm_pkg::ST_DG_CHK;
         gfpm_pkg::ST_DG_CHK: begin
            // degree of g is the highest nonzero entry seen
            if (g_data != '0) begin
               d_in    = i_ff[PW-1:0];
               d_ok_in = 1'b1;
            end
            if (i_ff == AW'(gfpm_pkg::DEG_T)) begin
               i_in     = '0;
               j_in     = '0;
               red_in   = 1'b0;
               state_in = gfpm_pkg::ST_PM_RD;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = gfpm_pkg::ST_DG_RD;
            end
         end
         gfpm_pkg::ST_PM_RD: state_in = gfpm_pkg::ST_LD;
         gfpm_pkg::ST_LD: begin
            x_in     = red_ff ? lead_ff : a_data;
            y_in     = red_ff ? g_data : b_data;
            acc_in   = '0;
            bit_in   = gfpm_pkg::BIT_W'(M - 1);
            state_in = gfpm_pkg::ST_MUL;
         end
         gfpm_pkg::ST_MUL: begin
            acc_in = mul_next;
            y_in   = {y_ff[M-2:0], 1'b0};
            if (bit_ff == '0) begin
               state_in = gfpm_pkg::ST_WB;
            end else begin
               bit_in = bit_ff - 1'b1;
            end
         end
         gfpm_pkg::ST_WB: begin
            p_we = 1'b1;
            if (!red_ff) begin
               if (j_ff == PW'(gfpm_pkg::DEG_T)) begin
                  j_in = '0;
                  if (i_ff == AW'(gfpm_pkg::DEG_T)) begin
                     if (d_ok_ff) begin
                        i_in     = AW'(gfpm_pkg::PROD_LEN - 1);
                        red_in   = 1'b1;
                        state_in = gfpm_pkg::ST_RL_RD;
                     end else begin
                        k_in     = '0;
                        state_in = gfpm_pkg::ST_O_EV;
                     end
                  end else begin
                     i_in     = i_ff + 1'b1;
                     state_in = gfpm_pkg::ST_PM_RD;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = gfpm_pkg::ST_PM_RD;
               end
            end else begin
               if (j_ff == d_ff) begin
                  if (i_ff == AW'(d_ff)) begin
                     k_in     = '0;
                     red_in   = 1'b0;
                     state_in = gfpm_pkg::ST_O_EV;
                  end else begin
                     i_in     = i_ff - 1'b1;
                     state_in = gfpm_pkg::ST_RL_RD;
                  end
               end else begin
                  j_in     = j_ff + 1'b1;
                  state_in = gfpm_pkg::ST_RJ_RD;
               end
            end
         end
         gfpm_pkg::ST_RL_RD: state_in = gfpm_pkg::ST_RL_LEAD;
         gfpm_pkg::ST_RL_LEAD: begin
            // leading coefficient taken before this row changes it
            lead_in  = p_q;
            j_in     = '0;
            state_in = gfpm_pkg::ST_RJ_RD;
         end
         gfpm_pkg::ST_RJ_RD: state_in = gfpm_pkg::ST_LD;
         gfpm_pkg::ST_O_EV:  state_in = gfpm_pkg::ST_O_OD;
         gfpm_pkg::ST_O_OD: begin
            even_in  = p_q;
            state_in = gfpm_pkg::ST_O_PUT;
         end
         gfpm_pkg::ST_O_PUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.coef_even  = even_ff;
               rsp_in.coef_odd   = (odd_addr <= AW'(gfpm_pkg::DEG_T)) ? p_q : '0;
               rsp_in.pair_index = k_ff;
               rsp_in.last       = (k_ff == KW'(gfpm_pkg::PAIRS - 1));
               if (k_ff == KW'(gfpm_pkg::PAIRS - 1)) begin
                  state_in = gfpm_pkg::ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = gfpm_pkg::ST_O_EV;
               end
            end
         end
         default: state_in = gfpm_pkg::ST_IDLE;
      endcase
   end

   assign req_stall   = (state_ff != gfpm_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign csr_ready   = 1'b1;

   a_put_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gfpm_pkg::ST_O_PUT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("pending pair not loaded into output register");

   a_last_pair: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> rsp_ff.pair_index == KW'(gfpm_pkg::PAIRS - 1))
      else $error("last flag on wrong pair");

   a_red_needs_deg: assert property (@(posedge clock) disable iff (reset)
      (state_ff == gfpm_pkg::ST_RL_RD || state_ff == gfpm_pkg::ST_RJ_RD
       || state_ff == gfpm_pkg::ST_RL_LEAD) |-> (d_ok_ff && red_ff))
      else $error("reduction running without a degree for g");

   a_p_addr: assert property (@(posedge clock) disable iff (reset)
      p_we |-> p_raddr <= AW'(gfpm_pkg::PROD_LEN - 1))
      else $error("product store write out of range");

endmodule
